/* hdl/mtdl_pkg.sv */
// Shared types and constants for the two-way descending merge block.
// Depends on nothing; every other file in hdl/ uses it.
package mtdl_pkg;

  localparam int VALUE_W        = 31;
  localparam int OP_W           = 2;
  localparam int LIST_DEPTH_DEF = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_MERGE  = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_MERGE = 1'b1
  } state_t;

  // control from the sequencer to one list store
  typedef struct packed {
    logic push;   // push request (zero / full filtered in the store)
    logic clear;  // drop all entries after a merge run
  } list_ctrl_t;

endpackage

/* hdl/mtdl_if.sv */
// Valid/ready channel interfaces for the merge block: input items and results.
// Depends on mtdl_pkg for field widths.
interface mtdl_in_if;
  logic                         valid;
  logic                         ready;
  logic [mtdl_pkg::OP_W-1:0]    operation;
  logic [mtdl_pkg::VALUE_W-1:0] value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface mtdl_out_if;
  logic                         valid;
  logic                         ready;
  logic [mtdl_pkg::VALUE_W-1:0] merged_value;
  logic                         last;
  logic                         empty_res;

  modport source (output valid, merged_value, last, empty_res, input ready);
  modport sink   (input valid, merged_value, last, empty_res, output ready);
endinterface

/* hdl/mtdl_list.sv */
// One list store: synchronous memory, fill count, push and head read port.
// Depends on mtdl_pkg.
module mtdl_list #(
  parameter int LIST_DEPTH = mtdl_pkg::LIST_DEPTH_DEF,
  parameter int CW         = $clog2(LIST_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mtdl_pkg::list_ctrl_t         ctrl,
  input  logic [mtdl_pkg::VALUE_W-1:0] push_value,
  input  logic [CW-1:0]                raddr,
  output logic [mtdl_pkg::VALUE_W-1:0] rdata,
  output logic [CW-1:0]                count
);
  import mtdl_pkg::*;

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [VALUE_W-1:0] mem [LIST_DEPTH];
  logic               wr_en;
  logic [AW-1:0]      rd_idx;

  assign wr_en = ctrl.push && (push_value != '0) && (count < CW'(LIST_DEPTH));
  // index one past the end reads entry 0; that data is never used
  assign rd_idx = (raddr < CW'(LIST_DEPTH)) ? AW'(raddr) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (wr_en) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(count)] <= push_value;
    end
    rdata <= mem[rd_idx];
  end

endmodule

/* hdl/merge_two_descending_lists_core.sv */
// Two-way merge of two descending lists held in synchronous memories.
// Depends on mtdl_pkg, mtdl_if and mtdl_list.
//
//  channel | dir | payload                           | handshake
//  --------+-----+-----------------------------------+-------------
//  in_ch   | in  | operation, value                  | valid/ready
//  out_ch  | out | merged_value, last, empty_res     | valid/ready
//
// Pushes are accepted back to back.
// A merge first primes the memory read ports with both head addresses, then
// emits one result per cycle while the output is not stalled (countA+countB
// results, or one empty result), paced by the registered reads of both lists.
// Input is held off while a merge run is in progress; output stalls freeze
// the read indexes so the registered heads stay valid.
// Reset (rst, synchronous) empties both lists and the output register.
module merge_two_descending_lists_core #(
  parameter int LIST_DEPTH = mtdl_pkg::LIST_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  mtdl_in_if.sink    in_ch,
  mtdl_out_if.source out_ch
);
  import mtdl_pkg::*;

  localparam int CW = $clog2(LIST_DEPTH + 1);

  state_t             state, state_next;
  logic [CW-1:0]      idx_a, idx_a_next;
  logic [CW-1:0]      idx_b, idx_b_next;
  logic [CW-1:0]      count_a, count_b;
  logic [VALUE_W-1:0] head_a, head_b;
  list_ctrl_t         ctrl_a, ctrl_b;

  logic               out_valid;
  logic [VALUE_W-1:0] merged_value;
  logic               last;
  logic               empty_res;

  logic               in_fire, slot_free, take_a, clear_lists;
  logic               load;
  logic [VALUE_W-1:0] load_value;
  logic               load_last, load_empty;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid || out_ch.ready;
  assign take_a    = (idx_a < count_a) && ((idx_b >= count_b) || (head_a >= head_b));

  assign ctrl_a.push  = in_fire && (in_ch.operation == OP_PUSH_A);
  assign ctrl_a.clear = clear_lists;
  assign ctrl_b.push  = in_fire && (in_ch.operation == OP_PUSH_B);
  assign ctrl_b.clear = clear_lists;

  mtdl_list #(.LIST_DEPTH(LIST_DEPTH), .CW(CW)) u_list_a (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_a),
    .push_value (in_ch.value),
    .raddr      (idx_a_next),
    .rdata      (head_a),
    .count      (count_a)
  );

  mtdl_list #(.LIST_DEPTH(LIST_DEPTH), .CW(CW)) u_list_b (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_b),
    .push_value (in_ch.value),
    .raddr      (idx_b_next),
    .rdata      (head_b),
    .count      (count_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx_a <= '0;
      idx_b <= '0;
    end else begin
      state <= state_next;
      idx_a <= idx_a_next;
      idx_b <= idx_b_next;
    end
  end

  always_comb begin
    state_next  = state;
    idx_a_next  = idx_a;
    idx_b_next  = idx_b;
    load        = 1'b0;
    load_value  = '0;
    load_last   = 1'b0;
    load_empty  = 1'b0;
    clear_lists = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire && (in_ch.operation == OP_MERGE)) begin
          // addresses of both heads go to the memories this cycle
          state_next = ST_MERGE;
          idx_a_next = '0;
          idx_b_next = '0;
        end
      end
      ST_MERGE: begin
        if (slot_free) begin
          load = 1'b1;
          if ((count_a == '0) && (count_b == '0)) begin
            load_last  = 1'b1;
            load_empty = 1'b1;
          end else begin
            if (take_a) begin
              load_value = head_a;
              idx_a_next = idx_a + 1'b1;
            end else begin
              load_value = head_b;
              idx_b_next = idx_b + 1'b1;
            end
            load_last = (idx_a_next == count_a) && (idx_b_next == count_b);
          end
          if (load_last) begin
            clear_lists = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      merged_value <= load_value;
      last         <= load_last;
      empty_res    <= load_empty;
    end
  end

  assign in_ch.ready         = (state == ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.merged_value = merged_value;
  assign out_ch.last         = last;
  assign out_ch.empty_res    = empty_res;

endmodule

/* hdl/mtdl_check.sv */
// Port-level checks for the merge block, bound to the top level.
// Depends on mtdl_pkg and merge_two_descending_lists_core.
module mtdl_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mtdl_pkg::VALUE_W-1:0] merged_value,
  input logic                         last,
  input logic                         empty_res
);
  import mtdl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(merged_value) && $stable(last)
      && $stable(empty_res))
    else $error("result changed while stalled");

  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> last && (merged_value == '0))
    else $error("empty result malformed");

  // zero pushes are dropped, so real results are never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !empty_res |-> merged_value != '0)
    else $error("zero value in merged run");

  // no input item is taken while a run is still being emitted
  a_run_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input accepted mid-run");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind merge_two_descending_lists_core mtdl_check u_mtdl_check (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .merged_value (out_ch.merged_value),
  .last         (out_ch.last),
  .empty_res    (out_ch.empty_res)
);
